// File: sv/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// shared types and codes of the 16-bit register pair alu
// ----------------------------------------------------------------------------
package rpa_pkg;

  // operation codes
  localparam logic [2:0] OP_INC  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_LDHL = 3'd2;
  localparam logic [2:0] OP_LOAD = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  // register pair codes
  localparam logic [2:0] PAIR_AF = 3'd0;
  localparam logic [2:0] PAIR_BC = 3'd1;
  localparam logic [2:0] PAIR_DE = 3'd2;
  localparam logic [2:0] PAIR_HL = 3'd3;
  localparam logic [2:0] PAIR_SP = 3'd4;

  // low bits of F that the flag ops keep
  localparam logic [7:0] F_KEEP_MASK = 8'h0F;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } rpa_cmd_t;

endpackage

// File: sv/rpa_ctrl.sv
// ----------------------------------------------------------------------------
// rpa_ctrl
// handshake controller: capture, execute, present the result word
// ----------------------------------------------------------------------------
module rpa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rpa_pkg::rpa_cmd_t cmd_o
);
  import rpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   take;

  // a new word may enter while the finished one leaves
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_DONE) && out_ready_i);
  assign take        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = take;
  assign cmd_o.execute = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (take) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q     <= S_DONE;
          out_valid_q <= 1'b1;
        end
        S_DONE: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= take ? S_EXEC : S_IDLE;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: sv/rpa_dp.sv
// ----------------------------------------------------------------------------
// rpa_dp
// register pairs, 16-bit adder with flag logic and result register
// ----------------------------------------------------------------------------
module rpa_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpa_pkg::rpa_cmd_t cmd_i,
  input  logic [2:0]        opcode_i,
  input  logic [2:0]        target_pair_i,
  input  logic [2:0]        source_pair_i,
  input  logic signed [15:0] step_amount_i,
  input  logic signed [7:0] signed_offset_i,
  input  logic [15:0]       load_value_i,
  output logic [15:0]       pair_value_o,
  output logic              zero_flag_o,
  output logic              subtract_flag_o,
  output logic              half_carry_flag_o,
  output logic              carry_flag_o,
  output logic              bad_pair_error_o
);
  import rpa_pkg::*;

  // captured word
  logic [2:0]  op_q, tgt_q, src_q;
  logic [15:0] step_q, load_q;
  logic [7:0]  off_q;

  // architectural pairs
  logic [15:0] af_q, bc_q, de_q, hl_q, sp_q;
  logic [15:0] af_d, bc_d, de_d, hl_d, sp_d;

  // result
  logic [15:0] value_q, value_d;
  logic        err_q, err_d;

  logic [15:0] tgt_val, src_val, add_a, add_b, inc_sum;
  logic [16:0] sum17;
  logic [4:0]  nib_sum;
  logic        tgt_ok, src_ok;
  logic        wr_en, flag_en;
  logic [15:0] wr_val;
  logic [7:0]  f_new;

  function automatic logic [15:0] pick(input logic [2:0] code, input logic [15:0] af,
                                       input logic [15:0] bc, input logic [15:0] de,
                                       input logic [15:0] hl, input logic [15:0] sp);
    logic [15:0] r;
    case (code)
      PAIR_AF: r = af;
      PAIR_BC: r = bc;
      PAIR_DE: r = de;
      PAIR_HL: r = hl;
      PAIR_SP: r = sp;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      tgt_q  <= target_pair_i;
      src_q  <= source_pair_i;
      step_q <= step_amount_i;
      off_q  <= signed_offset_i;
      load_q <= load_value_i;
    end
  end

  assign tgt_val = pick(tgt_q, af_q, bc_q, de_q, hl_q, sp_q);
  assign src_val = pick(src_q, af_q, bc_q, de_q, hl_q, sp_q);
  assign tgt_ok  = (tgt_q <= PAIR_SP);
  assign src_ok  = (src_q <= PAIR_SP);

  // shared adder for add and offset load
  assign add_a   = (op_q == OP_ADD) ? tgt_val : sp_q;
  assign add_b   = (op_q == OP_ADD) ? src_val : {{8{off_q[7]}}, off_q};
  assign sum17   = {1'b0, add_a} + {1'b0, add_b};
  assign nib_sum = {1'b0, add_a[3:0]} + {1'b0, add_b[3:0]};
  assign inc_sum = tgt_val + step_q;

  always_comb begin
    err_d   = 1'b0;
    wr_en   = 1'b0;
    wr_val  = 16'h0000;
    flag_en = 1'b0;
    f_new   = (af_q[7:0] & F_KEEP_MASK)
            | {(op_q == OP_ADD) && af_q[7], 1'b0, nib_sum[4], sum17[16], 4'h0};
    unique case (op_q)
      OP_INC: begin
        if (!tgt_ok || tgt_q == PAIR_AF) begin
          err_d = 1'b1;
        end else begin
          wr_en  = 1'b1;
          wr_val = inc_sum;
        end
      end
      OP_ADD: begin
        if (!src_ok || (tgt_q != PAIR_HL && tgt_q != PAIR_SP)) begin
          err_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_val  = sum17[15:0];
          flag_en = 1'b1;
        end
      end
      OP_LDHL: begin
        wr_en   = 1'b1;
        wr_val  = sum17[15:0];
        flag_en = 1'b1;
      end
      OP_LOAD: begin
        if (!tgt_ok) begin
          err_d = 1'b1;
        end else begin
          wr_en  = 1'b1;
          wr_val = load_q;
        end
      end
      OP_READ: begin
        if (!tgt_ok) begin
          err_d = 1'b1;
        end else begin
          wr_val = tgt_val;
        end
      end
      default: err_d = 1'b1;
    endcase
    value_d = err_d ? 16'h0000 : wr_val;
  end

  // offset load always lands in hl, the rest in the target pair
  always_comb begin
    logic [2:0] dst;
    dst  = (op_q == OP_LDHL) ? PAIR_HL : tgt_q;
    af_d = af_q;
    bc_d = bc_q;
    de_d = de_q;
    hl_d = hl_q;
    sp_d = sp_q;
    if (flag_en) begin
      af_d = {af_q[15:8], f_new};
    end
    if (wr_en) begin
      case (dst)
        PAIR_AF: af_d = wr_val;
        PAIR_BC: bc_d = wr_val;
        PAIR_DE: de_d = wr_val;
        PAIR_HL: hl_d = wr_val;
        PAIR_SP: sp_d = wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q <= 16'h0000;
      bc_q <= 16'h0000;
      de_q <= 16'h0000;
      hl_q <= 16'h0000;
      sp_q <= 16'h0000;
    end else if (cmd_i.execute) begin
      af_q <= af_d;
      bc_q <= bc_d;
      de_q <= de_d;
      hl_q <= hl_d;
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      value_q <= value_d;
      err_q   <= err_d;
    end
  end

  // flags come straight from F, which moves only on execute and reset
  assign pair_value_o      = value_q;
  assign zero_flag_o       = af_q[7];
  assign subtract_flag_o   = af_q[6];
  assign half_carry_flag_o = af_q[5];
  assign carry_flag_o      = af_q[4];
  assign bad_pair_error_o  = err_q;

endmodule

// File: sv/register_pair_alu_16bit.sv
// an accepted word passes through S_EXEC, where the pairs and the result register
// load, to S_DONE with the result valid; the next word is taken in the cycle
//   the result leaves, and none while a word is in S_EXEC or its result is held
// reset: rst_ni low clears AF, BC, DE, HL, SP and the controller to idle
// ----------------------------------------------------------------------------
// register_pair_alu_16bit
// sm83-style register pair unit: increment, 16-bit add, sp+offset into hl,
// load and read of the AF, BC, DE, HL and SP pairs
// ----------------------------------------------------------------------------
module register_pair_alu_16bit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input word channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         opcode_i,
  input  logic [2:0]         target_pair_i,
  input  logic [2:0]         source_pair_i,
  input  logic signed [15:0] step_amount_i,
  input  logic signed [7:0]  signed_offset_i,
  input  logic [15:0]        load_value_i,
  // result word channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        pair_value_o,
  output logic               zero_flag_o,
  output logic               subtract_flag_o,
  output logic               half_carry_flag_o,
  output logic               carry_flag_o,
  output logic               bad_pair_error_o
);
  import rpa_pkg::*;

  // commands: capture on input handshake, execute in the cycle after it
  rpa_cmd_t cmd;

  // controller owns the handshakes and sequencing
  rpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath holds the pairs, the adder and the result register
  rpa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .opcode_i          (opcode_i),
    .target_pair_i     (target_pair_i),
    .source_pair_i     (source_pair_i),
    .step_amount_i     (step_amount_i),
    .signed_offset_i   (signed_offset_i),
    .load_value_i      (load_value_i),
    .pair_value_o      (pair_value_o),
    .zero_flag_o       (zero_flag_o),
    .subtract_flag_o   (subtract_flag_o),
    .half_carry_flag_o (half_carry_flag_o),
    .carry_flag_o      (carry_flag_o),
    .bad_pair_error_o  (bad_pair_error_o)
  );

endmodule
